@@ hdl/ptsq_pkg.sv @@
// Shared types and constants for the PWM tone sequencer.
`timescale 1ns / 1ps
package ptsq_pkg;

	localparam int MAX_NOTES  = 64;
	localparam int SLOT_W     = $clog2(MAX_NOTES);
	localparam int POS_W      = 7;
	localparam int TONE_W     = 16;
	localparam int HOLD_W     = 16;
	localparam int PERIOD_W   = 16;
	localparam int CLK_HZ_W   = 29;
	localparam int PRESC_W    = 16;
	localparam int PROD_W     = PERIOD_W + TONE_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = CLK_HZ_W;

	localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = CLK_HZ_W'(16000000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(999);

	// item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLK_HZ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'd1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] slot;
		logic [TONE_W-1:0] tone_hz;
		logic [HOLD_W-1:0] hold_ms;
		logic [POS_W-1:0]  length;
	} item_t;

	typedef struct packed {
		logic [PRESC_W-1:0] prescaler;
		logic               pwm_on;
		logic               busy_res;
		logic               finished;
		logic [POS_W-1:0]   position;
	} result_t;

endpackage

@@ hdl/pwm_tone_sequencer.sv @@
// Top level of the PWM tone sequencer: note store, play sequencer and status word.
`timescale 1ns / 1ps
// Each word returns one status word, on result with done high for one cycle.
// Load, start, spare kinds and ticks that load no note go from accept straight to S_REPORT.
// A tick that loads a note passes S_READ and S_CALC; the unit skips the divide for a rest or a zero
// divisor, else runs the 29-step serial divider. Busy stays high from accept until the status shows.
// Reset (arst_n low) stops playback and restores the default timer registers at once;
// the note store is not cleared and no clearing pass runs.
module pwm_tone_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  ptsq_pkg::item_t                     item,
	output logic                                done,
	output ptsq_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [ptsq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptsq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_REPORT} state_t;

	state_t                                 state_q;
	logic [ptsq_pkg::CLK_HZ_W-1:0]          clk_hz_q;
	logic [ptsq_pkg::PERIOD_W-1:0]          period_q;
	logic                                   playing_q;
	logic [ptsq_pkg::POS_W-1:0]             next_slot_q;
	logic [ptsq_pkg::HOLD_W-1:0]            remaining_q;
	logic [ptsq_pkg::POS_W-1:0]             seq_len_q;
	logic [ptsq_pkg::PRESC_W-1:0]           presc_q;
	logic                                   fin_q;
	logic                                   done_q;
	ptsq_pkg::result_t                      result_q;

	// note store
	logic [ptsq_pkg::TONE_W-1:0]            tone_mem [ptsq_pkg::MAX_NOTES];
	logic [ptsq_pkg::HOLD_W-1:0]            hold_mem [ptsq_pkg::MAX_NOTES];
	logic [ptsq_pkg::TONE_W-1:0]            rd_tone_q;
	logic [ptsq_pkg::HOLD_W-1:0]            rd_hold_q;

	logic                                   accept;
	logic [ptsq_pkg::HOLD_W-1:0]            rem_dec;
	logic [ptsq_pkg::POS_W-1:0]             len_sat;
	logic                                   pu_go;
	logic                                   pu_done;
	logic [ptsq_pkg::PRESC_W-1:0]           pu_presc;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign pu_go  = (state_q == S_READ);

	// count down the current note, holding at zero
	assign rem_dec = (remaining_q != '0) ? remaining_q - ptsq_pkg::HOLD_W'(1) : '0;
	// clamp the requested length to the store depth
	assign len_sat = (item.length > ptsq_pkg::POS_W'(ptsq_pkg::MAX_NOTES))
		? ptsq_pkg::POS_W'(ptsq_pkg::MAX_NOTES) : item.length;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= ptsq_pkg::CLK_HZ_RESET;
			period_q <= ptsq_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ptsq_pkg::CFG_CLK_HZ: clk_hz_q <= cfg_data;
				ptsq_pkg::CFG_PERIOD: period_q <= cfg_data[ptsq_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// write on a load word; read the slot about to play every cycle
	always_ff @(posedge clk) begin
		if (accept && item.kind == ptsq_pkg::KIND_LOAD) begin
			tone_mem[item.slot] <= item.tone_hz;
			hold_mem[item.slot] <= item.hold_ms;
		end
		rd_tone_q <= tone_mem[next_slot_q[ptsq_pkg::SLOT_W-1:0]];
		rd_hold_q <= hold_mem[next_slot_q[ptsq_pkg::SLOT_W-1:0]];
	end

	ptsq_presc_unit u_presc (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (pu_go),
		.tone_hz        (rd_tone_q),
		.timer_period   (period_q),
		.timer_clock_hz (clk_hz_q),
		.done           (pu_done),
		.prescaler      (pu_presc)
	);

	// play sequencer and status word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			playing_q   <= 1'b0;
			next_slot_q <= '0;
			remaining_q <= '0;
			seq_len_q   <= '0;
			presc_q     <= '0;
			fin_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fin_q   <= 1'b0;
						state_q <= S_REPORT;
						case (item.kind)
							ptsq_pkg::KIND_START: begin
								if (!playing_q) begin
									seq_len_q   <= len_sat;
									playing_q   <= 1'b1;
									next_slot_q <= '0;
									remaining_q <= '0;
									presc_q     <= '0;
								end
							end
							ptsq_pkg::KIND_TICK: begin
								if (playing_q) begin
									remaining_q <= rem_dec;
									if (rem_dec == '0) begin
										if (next_slot_q < seq_len_q) begin
											// store data for this slot lands this edge
											state_q <= S_READ;
										end else begin
											// last note done: stop the buzzer
											presc_q   <= '0;
											playing_q <= 1'b0;
											fin_q     <= 1'b1;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					// unit takes the tone now; advance to the next slot
					remaining_q <= rd_hold_q;
					next_slot_q <= next_slot_q + ptsq_pkg::POS_W'(1);
					state_q     <= S_CALC;
				end
				S_CALC: begin
					if (pu_done) begin
						presc_q <= pu_presc;
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					result_q.prescaler <= presc_q;
					result_q.pwm_on    <= playing_q;
					result_q.busy_res  <= playing_q;
					result_q.finished  <= fin_q;
					result_q.position  <= next_slot_q;
					done_q             <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("status word shown while a word is in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not raise busy");

	a_finish_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.finished |-> !result.pwm_on && result.prescaler == '0)
		else $error("sequence end left the buzzer on");

	a_unit_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		pu_done |-> state_q == S_CALC)
		else $error("prescaler unit finished outside the calc state");

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.position <= ptsq_pkg::POS_W'(ptsq_pkg::MAX_NOTES))
		else $error("position beyond store depth");
`endif

endmodule

@@ hdl/ptsq_presc_unit.sv @@
// Prescaler unit: one multiply, then a restoring divider one quotient bit per cycle.
`timescale 1ns / 1ps
module ptsq_presc_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [ptsq_pkg::TONE_W-1:0]       tone_hz,
	input  logic [ptsq_pkg::PERIOD_W-1:0]     timer_period,
	input  logic [ptsq_pkg::CLK_HZ_W-1:0]     timer_clock_hz,
	output logic                              done,
	output logic [ptsq_pkg::PRESC_W-1:0]      prescaler
);

	localparam int CNT_W = $clog2(ptsq_pkg::CLK_HZ_W);

	typedef enum logic [1:0] {PU_IDLE, PU_MUL, PU_CHK, PU_DIV} pu_state_t;

	pu_state_t                         state_q;
	logic [ptsq_pkg::TONE_W-1:0]       hz_q;
	logic [ptsq_pkg::PROD_W-1:0]       prod_q;
	logic [ptsq_pkg::PROD_W-1:0]       divisor_q;
	logic [ptsq_pkg::PROD_W-1:0]       rem_q;
	logic [ptsq_pkg::CLK_HZ_W-1:0]     quo_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              done_q;
	logic [ptsq_pkg::PRESC_W-1:0]      presc_q;

	logic [ptsq_pkg::PROD_W:0]         shifted;
	logic [ptsq_pkg::PROD_W+1:0]       diff;
	logic                              fits;
	logic [ptsq_pkg::PROD_W-1:0]       rem_next;
	logic [ptsq_pkg::CLK_HZ_W-1:0]     quo_next;

	// one restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		shifted  = {rem_q, quo_q[ptsq_pkg::CLK_HZ_W-1]};
		diff     = {1'b0, shifted} - {2'b00, divisor_q};
		fits     = !diff[ptsq_pkg::PROD_W+1];
		rem_next = fits ? diff[ptsq_pkg::PROD_W-1:0] : shifted[ptsq_pkg::PROD_W-1:0];
		quo_next = {quo_q[ptsq_pkg::CLK_HZ_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PU_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				PU_IDLE: begin
					if (go) begin
						hz_q    <= tone_hz;
						state_q <= PU_MUL;
					end
				end
				PU_MUL: begin
					prod_q  <= timer_period * hz_q;
					state_q <= PU_CHK;
				end
				PU_CHK: begin
					// rest or a divisor of zero gives prescaler zero
					if (prod_q <= ptsq_pkg::PROD_W'(1)) begin
						presc_q <= '0;
						done_q  <= 1'b1;
						state_q <= PU_IDLE;
					end else begin
						divisor_q <= prod_q - ptsq_pkg::PROD_W'(1);
						rem_q     <= '0;
						quo_q     <= timer_clock_hz;
						cnt_q     <= CNT_W'(ptsq_pkg::CLK_HZ_W - 1);
						state_q   <= PU_DIV;
					end
				end
				PU_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						// saturate the quotient to the prescaler range
						presc_q <= (|quo_next[ptsq_pkg::CLK_HZ_W-1:ptsq_pkg::PRESC_W])
							? '1 : quo_next[ptsq_pkg::PRESC_W-1:0];
						done_q  <= 1'b1;
						state_q <= PU_IDLE;
					end
				end
				default: begin
					state_q <= PU_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign prescaler = presc_q;

endmodule

@@ tb/sv/pwm_tone_sequencer_tb.sv @@
// Self-checking testbench for the PWM tone sequencer: directed songs, timer sweeps, random play.
`timescale 1ns / 1ps
module pwm_tone_sequencer_tb;
	import ptsq_pkg::*;

	// unused item kind, ignored by the block
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int ITEM_W        = $bits(item_t);
	localparam int WORD_TARGET   = 1200;  // words that change the player state
	localparam int STALL_LIMIT   = 2000;  // cycles with no word moving either way
	localparam int SETTLE_CYCLES = 8;     // idle cycles after every owed status word is back
	localparam int MAX_GAP       = 18;
	localparam int REPORT_MAX    = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	item_t                 item      = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pwm_tone_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Player mirror: note store, play state and timer registers as the block should hold them.
	// Entries are only ever read after a load wrote them, so the store starts unknown.
	logic [TONE_W-1:0]   note_tone [MAX_NOTES];
	logic [HOLD_W-1:0]   note_hold [MAX_NOTES];
	logic                plr_playing = 1'b0;
	logic [POS_W-1:0]    plr_next    = '0;   // notes started so far
	logic [HOLD_W-1:0]   plr_left    = '0;   // ms left on the current note
	logic [POS_W-1:0]    plr_len     = '0;   // sequence length, already clipped to the store
	logic [PRESC_W-1:0]  plr_presc   = '0;
	logic [CLK_HZ_W-1:0] cur_clk_hz  = CLK_HZ_RESET;
	logic [PERIOD_W-1:0] cur_period  = PERIOD_RESET;

	result_t status_q [$];      // status words still owed by the block, oldest first
	int      mismatches   = 0;
	int      words_played = 0;
	int      stall_cycles = 0;
	bit      no_idle      = 1'b0;

	// Prescaler for one note: clock / (period * tone - 1), zero for a rest or a divisor
	// below one, clipped to the 16-bit timer range.
	function automatic logic [PRESC_W-1:0] timer_prescale(input logic [TONE_W-1:0] hz);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] quot;
		prod = PROD_W'(cur_period) * PROD_W'(hz);
		if (hz == '0 || prod <= 1)
			return '0;
		quot = PROD_W'(cur_clk_hz) / (prod - 1);
		return (quot > PROD_W'(16'hFFFF)) ? '1 : quot[PRESC_W-1:0];
	endfunction

	// Apply one accepted word to the mirror and queue the status word it must return.
	task automatic advance_player(input item_t w);
		result_t st;
		logic    ended;
		ended = 1'b0;
		case (w.kind)
			KIND_LOAD: begin
				// loads land even mid-song; a slot not yet reached plays the new note
				note_tone[w.slot] = w.tone_hz;
				note_hold[w.slot] = w.hold_ms;
				words_played++;
			end
			KIND_START: begin
				// a start while a song plays is dropped
				if (!plr_playing) begin
					plr_len     = (w.length > MAX_NOTES) ? POS_W'(MAX_NOTES) : w.length;
					plr_playing = 1'b1;
					plr_next    = '0;
					plr_left    = '0;
					plr_presc   = '0;
					words_played++;
				end
			end
			KIND_TICK: begin
				if (plr_playing) begin
					words_played++;
					if (plr_left != '0)
						plr_left--;
					// note time is up: advance to the next note or end the song
					if (plr_left == '0) begin
						if (plr_next < plr_len) begin
							plr_presc = timer_prescale(note_tone[plr_next[SLOT_W-1:0]]);
							plr_left  = note_hold[plr_next[SLOT_W-1:0]];
							plr_next++;
						end else begin
							plr_presc   = '0;
							plr_playing = 1'b0;
							ended       = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		st.prescaler = plr_presc;
		st.pwm_on    = plr_playing;
		st.busy_res  = plr_playing;
		st.finished  = ended;
		st.position  = plr_next;
		status_q.push_back(st);
	endtask

	// Compare every status word with the oldest one owed; outputs are sampled at the edge
	// that ends the strobe cycle.
	always @(posedge clk) begin
		result_t want;
		if (done) begin
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("tb: status word %h with nothing owed", result);
			end else begin
				want = status_q.pop_front();
				if (result.prescaler !== want.prescaler || result.pwm_on !== want.pwm_on ||
				    result.busy_res !== want.busy_res || result.finished !== want.finished ||
				    result.position !== want.position) begin
					mismatches++;
					// fields: prescaler, pwm_on, busy_res, finished, position
					if (mismatches <= REPORT_MAX)
						$display("tb: mismatch want %0d %b %b %b %0d got %0d %b %b %b %0d",
							want.prescaler, want.pwm_on, want.busy_res, want.finished,
							want.position, result.prescaler, result.pwm_on, result.busy_res,
							result.finished, result.position);
				end
			end
		end
	end

	// Watchdog: end the run once nothing has moved for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Random word of one kind; every other field is random so all bits toggle.
	function automatic item_t rand_word(input logic [1:0] kind);
		item_t w;
		w = ITEM_W'({$urandom, $urandom});
		w.kind = kind;
		return w;
	endfunction

	function automatic logic [TONE_W-1:0] pick_tone();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return TONE_W'($urandom_range(1, 3));
			2:       return '1;
			3:       return TONE_W'($urandom_range(20, 2000));
			default: return TONE_W'($urandom);
		endcase
	endfunction

	// Keep played notes short so songs finish in a few ticks per note.
	function automatic logic [HOLD_W-1:0] pick_hold();
		if ($urandom_range(0, 7) == 0)
			return HOLD_W'($urandom_range(4, 24));
		return HOLD_W'($urandom_range(0, 3));
	endfunction

	// Mostly short songs, now and then a long one or one past the store size.
	function automatic logic [POS_W-1:0] pick_length();
		case ($urandom_range(0, 19))
			14, 15, 16, 17: return POS_W'($urandom_range(7, 20));
			18:             return POS_W'($urandom_range(21, MAX_NOTES));
			19:             return POS_W'($urandom_range(MAX_NOTES + 1, 127));
			default:        return POS_W'($urandom_range(0, 6));
		endcase
	endfunction

	// Present one word, hold it until accepted, then update the mirror.
	// Start stays high between back-to-back words so it is never dropped and raised in one step.
	task automatic send_word(input item_t w);
		int gap;
		if ($urandom_range(0, 59) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		advance_player(w);
	endtask

	task automatic load_note(input logic [SLOT_W-1:0] slot, input logic [TONE_W-1:0] tone,
	                         input logic [HOLD_W-1:0] hold);
		item_t w;
		w         = rand_word(KIND_LOAD);
		w.slot    = slot;
		w.tone_hz = tone;
		w.hold_ms = hold;
		send_word(w);
	endtask

	task automatic begin_song(input logic [POS_W-1:0] len);
		item_t w;
		w        = rand_word(KIND_START);
		w.length = len;
		send_word(w);
	endtask

	// Drop start and wait until every owed status word is back and the block is quiet.
	task automatic drain_status();
		start <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both timer registers while nothing is in flight and no song plays.
	task automatic write_timer(input logic [CLK_HZ_W-1:0] hz, input logic [PERIOD_W-1:0] per);
		drain_status();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CLK_HZ;
		cfg_data  <= CFG_DATA_W'(hz);
		@(posedge clk);
		cur_clk_hz = hz;
		cfg_index <= CFG_PERIOD;
		cfg_data  <= CFG_DATA_W'(per);
		@(posedge clk);
		cur_period = per;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Tick until the song ends. With noise, mix in dropped starts, spare kinds and loads;
	// a load into a note still to come gets a short hold so the song stays short.
	task automatic play_out(input bit noisy);
		item_t w;
		int    pick;
		while (plr_playing) begin
			if (noisy && $urandom_range(0, 6) == 0) begin
				pick = $urandom_range(0, 2);
				w = rand_word(pick == 0 ? KIND_LOAD : (pick == 1 ? KIND_START : KIND_SPARE));
				if (w.kind == KIND_LOAD && w.slot >= plr_next && w.slot < plr_len)
					w.hold_ms = pick_hold();
				send_word(w);
			end
			send_word(rand_word(KIND_TICK));
		end
	endtask

	// Load every note the song will reach, start it and play it to the end.
	// Noise loads go only to slots past the song, which are reloaded before any later play.
	task automatic play_song(input logic [POS_W-1:0] len, input bit noisy);
		int    fill;
		item_t w;
		fill = (len > MAX_NOTES) ? MAX_NOTES : len;
		for (int s = 0; s < fill; s++) begin
			if (noisy && fill < MAX_NOTES && $urandom_range(0, 4) == 0) begin
				w      = rand_word(KIND_LOAD);
				w.slot = SLOT_W'($urandom_range(fill, MAX_NOTES - 1));
				send_word(w);
			end
			load_note(SLOT_W'(s), pick_tone(), pick_hold());
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_word(rand_word($urandom_range(0, 1) ? KIND_TICK : KIND_SPARE));
		begin_song(len);
		play_out(noisy);
	endtask

	// Idle words, empty song, field extremes, start while busy and a load mid-song.
	task automatic test_directed();
		send_word(rand_word(KIND_TICK));     // tick while idle: no effect
		send_word(rand_word(KIND_SPARE));    // unused kind: no effect
		begin_song('0);                      // empty song ends on the first tick
		send_word(rand_word(KIND_TICK));
		load_note(SLOT_W'(0), '0, '0);       // rest with zero hold
		load_note('1, '1, '1);               // last slot, top tone and hold, never played
		load_note(SLOT_W'(1), '1, HOLD_W'(1));
		load_note(SLOT_W'(2), TONE_W'(1), HOLD_W'(2));
		begin_song(POS_W'(3));
		begin_song('1);                      // start while busy: dropped
		send_word(rand_word(KIND_TICK));     // rest starts
		send_word(rand_word(KIND_TICK));     // top tone starts, one ms
		load_note(SLOT_W'(2), TONE_W'(440), '0);  // slot 2 not reached yet: new note plays
		play_out(1'b0);
	endtask

	// One timer setting followed by a couple of songs.
	task automatic timer_phase(input logic [CLK_HZ_W-1:0] hz, input logic [PERIOD_W-1:0] per);
		write_timer(hz, per);
		play_song(POS_W'($urandom_range(1, 8)), 1'b0);
		play_song(POS_W'($urandom_range(1, 8)), 1'b1);
	endtask

	// Sweep the timer registers through their corners, a few random points and back to reset.
	task automatic test_timer_settings();
		timer_phase(CLK_HZ_W'(1), PERIOD_W'(1));
		timer_phase('1, '1);
		timer_phase('1, PERIOD_W'(1));
		timer_phase(CLK_HZ_W'(1), '1);
		repeat (3)
			timer_phase(CLK_HZ_W'($urandom_range(1, 2**CLK_HZ_W - 1)),
			            PERIOD_W'($urandom_range(1, 2**PERIOD_W - 1)));
		timer_phase(CLK_HZ_RESET, PERIOD_RESET);
	endtask

	// Random songs with noise; retune the timer now and then between songs.
	task automatic test_random_play();
		logic [CLK_HZ_W-1:0] hz;
		logic [PERIOD_W-1:0] per;
		while (words_played < WORD_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				hz  = $urandom_range(0, 1) ? CLK_HZ_W'($urandom_range(1, 2**CLK_HZ_W - 1))
				                           : CLK_HZ_W'($urandom_range(1, 100000));
				per = $urandom_range(0, 2) == 0 ? PERIOD_W'($urandom_range(1, 4))
				                                : PERIOD_W'($urandom_range(1, 2**PERIOD_W - 1));
				write_timer(hz, per);
			end
			play_song(pick_length(), 1'b1);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_timer_settings();
		test_random_play();
		drain_status();
		if (mismatches == 0 && status_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
